@@ rtl/zstd_pkg.sv @@
// ============================================================================
// zstd_pkg: shared types and constants of the packed text decoder
// Holds the alphabet, register index and result types, plus the
// punctuation alphabet lookup used by the decode lanes.
// ============================================================================
package zstd_pkg;

    localparam int CodeW  = 5;
    localparam int CharW  = 7;
    localparam int NLanes = 3;
    localparam int NSlots = 4;

    localparam logic [5:0] WordLimitRst   = 6'd30;
    localparam logic [7:0] MinLengthRst   = 8'd5;
    localparam logic [7:0] LengthBoundRst = 8'd200;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [CharW-1:0] CHAR_SPACE   = 7'h20;
    localparam logic [CharW-1:0] CHAR_LOWER_A = 7'h61;
    localparam logic [CharW-1:0] CHAR_UPPER_A = 7'h41;

    typedef enum logic [1:0] {
        ALPHA_LOWER = 2'd0,
        ALPHA_UPPER = 2'd1,
        ALPHA_PUNCT = 2'd2
    } alpha_t;

    typedef enum logic [1:0] {
        CFG_WORD_LIMIT   = 2'd0,
        CFG_MIN_LENGTH   = 2'd1,
        CFG_LENGTH_BOUND = 2'd2
    } cfg_idx_t;

    // Decoder state carried from one code to the next.
    typedef struct packed {
        alpha_t alpha;
        logic   skip;
    } lane_state_t;

    // What one lane found in its code.
    typedef struct packed {
        logic             emit;
        logic [CharW-1:0] ch;
    } lane_out_t;

    // One result beat.
    typedef struct packed {
        logic             kind;
        logic [CharW-1:0] ch;
        logic             acc;
    } result_t;

    function automatic logic [CharW-1:0] punct_char(input logic [CodeW-1:0] idx);
        logic [CharW-1:0] c;
        case (idx)
            5'd0:    c = 7'h20;  // space
            5'd1:    c = 7'h5E;  // ^
            5'd2:    c = 7'h30;
            5'd3:    c = 7'h31;
            5'd4:    c = 7'h32;
            5'd5:    c = 7'h33;
            5'd6:    c = 7'h34;
            5'd7:    c = 7'h35;
            5'd8:    c = 7'h36;
            5'd9:    c = 7'h37;
            5'd10:   c = 7'h38;
            5'd11:   c = 7'h39;
            5'd12:   c = 7'h2E;  // .
            5'd13:   c = 7'h2C;  // ,
            5'd14:   c = 7'h21;  // !
            5'd15:   c = 7'h3F;  // ?
            5'd16:   c = 7'h5F;  // _
            5'd17:   c = 7'h23;  // #
            5'd18:   c = 7'h27;  // '
            5'd19:   c = 7'h22;  // "
            5'd20:   c = 7'h2F;  // /
            5'd21:   c = 7'h5C;  // backslash
            5'd22:   c = 7'h2D;  // -
            5'd23:   c = 7'h3A;  // :
            5'd24:   c = 7'h28;  // (
            5'd25:   c = 7'h29;  // )
            default: c = 7'h20;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/zstd_lane.sv @@
// ============================================================================
// zstd_lane: decode lane for one 5-bit text code
// Turns one code and the incoming shift/skip state into an optional
// character and the state handed to the next code.
// ============================================================================
module zstd_lane
    import zstd_pkg::*;
(
    input  logic [CodeW-1:0] code,
    input  lane_state_t      st_in,
    output lane_state_t      st_out,
    output lane_out_t        res
);

    logic [CodeW-1:0] idx;

    assign idx = code - 5'd6;

    always_comb begin
        st_out = st_in;
        res    = '0;
        if (st_in.skip) begin
            // Abbreviation index: consumed without effect.
            st_out.skip = 1'b0;
        end else if (code == 5'd0) begin
            res.emit     = 1'b1;
            res.ch       = CHAR_SPACE;
            st_out.alpha = ALPHA_LOWER;
        end else if (code <= 5'd3) begin
            st_out.skip  = 1'b1;
            st_out.alpha = ALPHA_LOWER;
        end else if (code == 5'd4) begin
            st_out.alpha = ALPHA_UPPER;
        end else if (code == 5'd5) begin
            st_out.alpha = ALPHA_PUNCT;
        end else begin
            res.emit     = 1'b1;
            st_out.alpha = ALPHA_LOWER;
            case (st_in.alpha)
                ALPHA_LOWER: res.ch = CHAR_LOWER_A + {2'b00, idx};
                ALPHA_UPPER: res.ch = CHAR_UPPER_A + {2'b00, idx};
                default:     res.ch = punct_char(idx);
            endcase
        end
    end

endmodule

@@ rtl/zstd_merge.sv @@
// ============================================================================
// zstd_merge: combines lane results into one word's result list
// Packs the found characters in order, updates the run counters and
// appends the run verdict when the run ends.
// ============================================================================
module zstd_merge
    import zstd_pkg::*;
(
    input  lane_out_t    lane_res [NLanes],
    input  logic         end_bit,
    input  logic [5:0]   words_seen,
    input  logic [7:0]   chars_emitted,
    input  logic [5:0]   word_limit,
    input  logic [7:0]   min_length,
    input  logic [7:0]   length_bound,
    output result_t      slots [NSlots],
    output logic [2:0]   count,
    output logic         run_end,
    output logic [5:0]   words_next,
    output logic [7:0]   chars_next
);

    logic [1:0] n_chars;
    logic [8:0] chars_sum;
    logic       ok;
    logic [2:0] pos;

    assign n_chars = {1'b0, lane_res[0].emit} + {1'b0, lane_res[1].emit}
                   + {1'b0, lane_res[2].emit};
    assign chars_sum  = {1'b0, chars_emitted} + {7'd0, n_chars};
    assign chars_next = chars_sum[8] ? 8'hFF : chars_sum[7:0];
    assign words_next = (words_seen == 6'h3F) ? 6'h3F : words_seen + 6'd1;

    assign run_end = end_bit || (words_next >= word_limit);
    assign ok      = end_bit && (chars_next >= min_length) && (chars_next < length_bound);

    always_comb begin
        for (int j = 0; j < NSlots; j++) begin
            slots[j] = '0;
        end
        pos = 3'd0;
        for (int i = 0; i < NLanes; i++) begin
            if (lane_res[i].emit) begin
                slots[pos[1:0]] = '{kind: KIND_CHAR, ch: lane_res[i].ch, acc: 1'b0};
                pos = pos + 3'd1;
            end
        end
        if (run_end) begin
            slots[pos[1:0]] = '{kind: KIND_VERDICT, ch: '0, acc: ok};
            pos = pos + 3'd1;
        end
        count = pos;
    end

endmodule

@@ rtl/zstring_text_decoder.sv @@
// ============================================================================
// zstring_text_decoder: packed text word decoder with run verdict
// Three decode lanes, a merge stage and a four-entry result buffer.
// ============================================================================
// Each input beat carries one 16-bit packed text word: bit 15 ends the run
// and bits 14..10, 9..5, 4..0 hold three 5-bit codes, taken high first. Three
// decode lanes handle the three codes in the same cycle, chaining the one-code
// shift and abbreviation-skip state from lane to lane, and a merge stage packs
// the characters found and, at the end of a run, a verdict beat (tuser high)
// telling downstream whether to keep the run's characters. A word's results
// (zero to four beats) sit in a result buffer and leave one beat per cycle
// while m_tready is high; tlast marks the final beat of each word. A new word
// is taken in the same cycle the previous word's last beat leaves, or whenever
// the buffer is empty, so words that yield no result never hold up the input.
// Configuration writes are accepted at any time and should only be issued
// while the block is idle.
// ============================================================================
module zstring_text_decoder
    import zstd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] packed_word
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [6:0] char_code, [7] accepted
    output logic        m_tuser,    // [0] kind
    output logic        m_tlast,
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    // Configuration registers.
    logic [5:0] word_limit_reg;
    logic [7:0] min_length_reg;
    logic [7:0] length_bound_reg;

    // Run state.
    lane_state_t st_reg;
    logic [5:0]  words_reg;
    logic [7:0]  chars_reg;

    // Result buffer: slot 0 is on the output.
    result_t     slot_reg  [NSlots];
    result_t     slot_next [NSlots];
    logic [2:0]  cnt_reg;
    logic [2:0]  cnt_next;

    lane_state_t lane_st  [NLanes+1];
    lane_out_t   lane_res [NLanes];
    result_t     new_slots [NSlots];
    logic [2:0]  new_cnt;
    logic        run_end;
    logic [5:0]  words_next;
    logic [7:0]  chars_next;
    logic        in_fire;
    logic        out_fire;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_limit_reg   <= WordLimitRst;
            min_length_reg   <= MinLengthRst;
            length_bound_reg <= LengthBoundRst;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_WORD_LIMIT:   word_limit_reg   <= cfg_data[5:0];
                CFG_MIN_LENGTH:   min_length_reg   <= cfg_data;
                CFG_LENGTH_BOUND: length_bound_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // The lanes decode the three codes of the word, each starting from
    // the state its higher neighbor leaves.
    assign lane_st[0] = st_reg;

    for (genvar g = 0; g < NLanes; g++) begin : g_lane
        zstd_lane u_lane (
            .code   (s_tdata[CodeW*(NLanes-g)-1 -: CodeW]),
            .st_in  (lane_st[g]),
            .st_out (lane_st[g+1]),
            .res    (lane_res[g])
        );
    end

    zstd_merge u_merge (
        .lane_res      (lane_res),
        .end_bit       (s_tdata[15]),
        .words_seen    (words_reg),
        .chars_emitted (chars_reg),
        .word_limit    (word_limit_reg),
        .min_length    (min_length_reg),
        .length_bound  (length_bound_reg),
        .slots         (new_slots),
        .count         (new_cnt),
        .run_end       (run_end),
        .words_next    (words_next),
        .chars_next    (chars_next)
    );

    // A new word may enter when the buffer is empty or its final beat is
    // leaving in this cycle.
    assign m_tvalid = (cnt_reg != 3'd0);
    assign out_fire = m_tvalid && m_tready;
    assign s_tready = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && m_tready);
    assign in_fire  = s_tvalid && s_tready;

    assign m_tdata = {slot_reg[0].acc, slot_reg[0].ch};
    assign m_tuser = slot_reg[0].kind;
    assign m_tlast = (cnt_reg == 3'd1);

    always_comb begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (in_fire) begin
            slot_next = new_slots;
            cnt_next  = new_cnt;
        end else if (out_fire) begin
            for (int j = 0; j < NSlots - 1; j++) begin
                slot_next[j] = slot_reg[j+1];
            end
            slot_next[NSlots-1] = '0;
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= 3'd0;
            st_reg    <= '{alpha: ALPHA_LOWER, skip: 1'b0};
            words_reg <= 6'd0;
            chars_reg <= 8'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (in_fire) begin
                if (run_end) begin
                    st_reg    <= '{alpha: ALPHA_LOWER, skip: 1'b0};
                    words_reg <= 6'd0;
                    chars_reg <= 8'd0;
                end else begin
                    st_reg    <= lane_st[NLanes];
                    words_reg <= words_next;
                    chars_reg <= chars_next;
                end
            end
        end
    end

    // The buffer never holds more than one word's four results.
    a_cnt_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'd4)
        else $error("result buffer count out of range");

    // A verdict is always the final beat of its word.
    a_verdict_last : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("verdict beat without tlast");

    // A word with the end bit clears the run counters.
    a_end_clears : assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata[15] |=> (words_reg == 6'd0) && (chars_reg == 8'd0))
        else $error("run state not cleared after end word");

    // Input is only taken once the buffer is about to be empty.
    a_ready_drain : assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (cnt_reg <= 3'd1))
        else $error("input taken while results still queued");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the packed text word decoder
// Streams 16-bit text words into the decoder and checks every result beat
// against a cycle-free prediction of the decoded characters and run verdicts.
// Runs a directed opening, then random runs under several register settings.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import zstd_pkg::*;

    // Glyphs of the punctuation alphabet, indexed by code minus six.
    localparam string PunctGlyphs = " ^0123456789.,!?_#'\"/\\-:()";

    // With no beat moving on any channel for this many cycles, the run is hung.
    localparam int QuietLimit = 2000;

    // Cycles allowed after the last expected beat before touching registers
    // or ending; a word with no results still updates the block's run state.
    localparam int SettleCycles = 8;

    // One expected result beat.
    typedef struct packed {
        logic       kind;
        logic [6:0] ch;
        logic       acc;
        logic       last;
    } text_beat_t;

    // Tracks the decoder's run state and register copies, turns every
    // accepted word into the beats it must produce, and checks the beats
    // that come out against them in order.
    class decode_board;
        logic [5:0]   word_limit;
        logic [7:0]   min_length;
        logic [7:0]   length_bound;
        alpha_t       alpha;
        logic         skip;
        logic [5:0]   words_seen;
        logic [7:0]   chars_seen;
        text_beat_t   due_beats[$];
        int           errors;

        function new();
            word_limit   = WordLimitRst;
            min_length   = MinLengthRst;
            length_bound = LengthBoundRst;
            errors       = 0;
            clear_run();
        endfunction

        function void clear_run();
            alpha      = ALPHA_LOWER;
            skip       = 1'b0;
            words_seen = '0;
            chars_seen = '0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [7:0] value);
            case (idx)
                CFG_WORD_LIMIT:   word_limit   = value[5:0];
                CFG_MIN_LENGTH:   min_length   = value;
                CFG_LENGTH_BOUND: length_bound = value;
                default: ;
            endcase
        endfunction

        function void add_char(logic [6:0] ch);
            due_beats.push_back('{kind: KIND_CHAR, ch: ch, acc: 1'b0, last: 1'b0});
            alpha = ALPHA_LOWER;
            if (chars_seen != 8'hFF) chars_seen++;
        endfunction

        function void add_verdict(logic keep);
            due_beats.push_back('{kind: KIND_VERDICT, ch: '0, acc: keep, last: 1'b0});
            clear_run();
        endfunction

        function void note_word(logic [15:0] w);
            logic [4:0] code;
            logic [4:0] idx;
            byte        glyph;
            int         before_cnt;
            before_cnt = due_beats.size();
            if (words_seen != 6'd63) words_seen++;
            // The three codes are taken from the top of the word down.
            for (int lane = 2; lane >= 0; lane--) begin
                code = w[lane*5 +: 5];
                idx  = code - 5'd6;
                if (skip) begin
                    skip = 1'b0;
                end else if (code == 5'd0) begin
                    add_char(CHAR_SPACE);
                end else if (code <= 5'd3) begin
                    // Abbreviation: its index code is swallowed and any shift dropped.
                    skip  = 1'b1;
                    alpha = ALPHA_LOWER;
                end else if (code == 5'd4) begin
                    alpha = ALPHA_UPPER;
                end else if (code == 5'd5) begin
                    alpha = ALPHA_PUNCT;
                end else begin
                    case (alpha)
                        ALPHA_LOWER: add_char(CHAR_LOWER_A + {2'b00, idx});
                        ALPHA_UPPER: add_char(CHAR_UPPER_A + {2'b00, idx});
                        default: begin
                            glyph = PunctGlyphs[idx];
                            add_char(glyph[6:0]);
                        end
                    endcase
                end
            end
            // The end bit wins over the word limit when both hold.
            if (w[15]) begin
                add_verdict(chars_seen >= min_length && chars_seen < length_bound);
            end else if (words_seen >= word_limit) begin
                add_verdict(1'b0);
            end
            if (due_beats.size() > before_cnt) begin
                due_beats[due_beats.size()-1].last = 1'b1;
            end
        endfunction

        function void check_beat(logic kind, logic [6:0] ch, logic acc, logic last);
            text_beat_t want;
            if (due_beats.size() == 0) begin
                $display("%0t: unexpected result beat kind=%0d char=%02h acc=%0d last=%0d",
                         $realtime, kind, ch, acc, last);
                errors++;
                return;
            end
            want = due_beats.pop_front();
            if (want.kind !== kind || want.ch !== ch || want.acc !== acc
                    || want.last !== last) begin
                $display("%0t: result mismatch, expected kind=%0d char=%02h acc=%0d last=%0d, got kind=%0d char=%02h acc=%0d last=%0d",
                         $realtime, want.kind, want.ch, want.acc, want.last,
                         kind, ch, acc, last);
                errors++;
            end
        endfunction

        function int pending();
            return due_beats.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;       // [15:0] packed_word
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;            // [6:0] char_code, [7] accepted
    logic        m_tuser;            // [0] kind
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_WORD_LIMIT;
    logic [7:0]  cfg_data = '0;

    // Percent chance, per cycle, that the sender holds back or the receiver stalls.
    int in_idle_pct  = 35;
    int out_idle_pct = 35;
    int quiet_cycles = 0;

    decode_board sb = new();

    zstring_text_decoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // The receiver decides at each falling edge whether to stall the next cycle.
    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= out_idle_pct);
    end

    // Result beats are sampled at the rising edge, before the block updates.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_beat(m_tuser, m_tdata[6:0], m_tdata[7], m_tlast);
        end
    end

    // Watchdog: any beat on any channel resets the count of quiet cycles.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QuietLimit) begin
            $display("%0t: no progress for %0d cycles", $realtime, QuietLimit);
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic logic [15:0] text_word(input logic e, input logic [4:0] a,
                                              input logic [4:0] b, input logic [4:0] c);
        return {e, a, b, c};
    endfunction

    // Random code leaning toward letters, with spaces, shifts and abbreviations.
    function automatic logic [4:0] rand_code();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55) return 5'($urandom_range(31, 6));
        if (roll < 67) return 5'd0;
        if (roll < 77) return 5'd4;
        if (roll < 87) return 5'd5;
        return 5'($urandom_range(3, 1));
    endfunction

    // Presents one word, holding it until the block takes it. Called and
    // returning at a falling edge.
    task automatic push_word(input logic [15:0] w);
        while ($urandom_range(99) < in_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = w;
        do @(posedge aclk); while (!s_tready);
        sb.note_word(w);
        @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, value);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Waits until every predicted beat has been seen, then lets the block settle.
    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SettleCycles) @(negedge aclk);
    endtask

    task automatic set_regs(input logic [5:0] wl, input logic [7:0] ml, input logic [7:0] lb);
        drain();
        write_reg(CFG_WORD_LIMIT, {2'b00, wl});
        write_reg(CFG_MIN_LENGTH, ml);
        write_reg(CFG_LENGTH_BOUND, lb);
    endtask

    // Mostly well-formed runs of random codes that end on the end bit, some
    // left open to run into the word limit, and some raw noise words.
    task automatic random_phase(input logic [5:0] wl, input logic [7:0] ml,
                                input logic [7:0] lb, input int idle, input int n_words);
        int         left;
        int         run_len;
        logic       closes;
        logic [15:0] w;
        set_regs(wl, ml, lb);
        in_idle_pct  = idle;
        out_idle_pct = idle;
        left = n_words;
        while (left > 0) begin
            if ($urandom_range(99) < 15) begin
                push_word(16'($urandom()));
                left--;
            end else begin
                run_len = $urandom_range(10, 1);
                if ($urandom_range(9) == 0) run_len = $urandom_range(64, 1);
                closes = ($urandom_range(99) < 85);
                for (int k = 1; k <= run_len && left > 0; k++) begin
                    w = text_word(closes && k == run_len, rand_code(), rand_code(), rand_code());
                    push_word(w);
                    left--;
                end
            end
        end
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed opening under the reset settings: limit 30, bounds 5 and 200.
        push_word(text_word(1'b0, 5'd0, 5'd0, 5'd0));      // three spaces
        push_word(text_word(1'b0, 5'd6, 5'd7, 5'd31));     // lowest and highest letters
        push_word(text_word(1'b0, 5'd4, 5'd6, 5'd31));     // shift lasts one code only
        push_word(text_word(1'b0, 5'd4, 5'd31, 5'd5));     // shift left pending at word end
        push_word(text_word(1'b0, 5'd6, 5'd5, 5'd6));      // carried shift, punctuation space
        push_word(text_word(1'b0, 5'd5, 5'd7, 5'd5));
        push_word(text_word(1'b0, 5'd31, 5'd4, 5'd5));     // last punctuation glyph
        push_word(text_word(1'b0, 5'd4, 5'd5, 5'd31));     // later shift replaces earlier
        push_word(text_word(1'b0, 5'd4, 5'd1, 5'd6));      // abbreviation drops shift, no output
        push_word(text_word(1'b0, 5'd2, 5'd6, 5'd3));      // index skip carried into next word
        push_word(text_word(1'b0, 5'd9, 5'd5, 5'd17));
        push_word(text_word(1'b0, 5'd4, 5'd0, 5'd6));      // space clears a pending shift
        push_word(text_word(1'b1, 5'd5, 5'd30, 5'd0));     // end bit, long run kept
        push_word(text_word(1'b1, 5'd0, 5'd0, 5'd0));      // end bit, run too short
        push_word(text_word(1'b1, 5'd1, 5'd1, 5'd1));      // verdict alone
        push_word(16'hFFFF);
        push_word(16'h7FFF);
        push_word(text_word(1'b0, 5'd4, 5'd4, 5'd4));
        push_word(text_word(1'b1, 5'd6, 5'd6, 5'd6));

        // Tight limits: the second word of a run hits the limit, and only an
        // empty run fits under a bound of one.
        set_regs(6'd2, 8'd0, 8'd1);
        push_word(text_word(1'b0, 5'd6, 5'd6, 5'd6));
        push_word(text_word(1'b0, 5'd6, 5'd6, 5'd6));
        push_word(text_word(1'b1, 5'd1, 5'd6, 5'd1));
        push_word(text_word(1'b0, 5'd3, 5'd7, 5'd7));
        push_word(text_word(1'b1, 5'd20, 5'd21, 5'd22));

        random_phase(6'd63, 8'd0, 8'd255, 35, 41);
        random_phase(6'd1, 8'd0, 8'd1, 35, 41);
        random_phase(6'd63, 8'd255, 8'd255, 35, 41);
        // A stretch where neither side ever holds back.
        random_phase(6'd63, 8'd0, 8'd255, 0, 41);
        random_phase(6'd12, 8'd3, 8'd20, 35, 41);
        random_phase(6'($urandom_range(63, 1)), 8'($urandom_range(20, 0)),
                     8'($urandom_range(255, 1)), 35, 41);
        random_phase(6'($urandom_range(8, 1)), 8'($urandom_range(6, 0)),
                     8'($urandom_range(30, 1)), 35, 41);

        drain();
        if (sb.errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/zstd_pkg.sv
rtl/zstd_lane.sv
rtl/zstd_merge.sv
rtl/zstring_text_decoder.sv
tb/tb.sv
